@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL file that carries checks.
// No dependencies; the bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define JAV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("label failed");
`define JAV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("label failed");
`else
`define JAV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define JAV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/jav_pkg.sv @@
// Shared types, constants and tables of the arm velocity controller.
// No dependencies.
package jav_pkg;
   localparam int JOINTS        = 5;
   localparam int JOINT_W       = $clog2(JOINTS);
   localparam int DRAIN_CYCLES  = 2;
   localparam int VEL_W         = 32;
   localparam int CSR_DATA_W    = 16;

   localparam logic signed [15:0] CURRENT_LIMIT_RST = 16'sd1536;
   localparam logic signed [15:0] SLEW_DEADZONE     = 16'sd3276;
   localparam logic signed [17:0] FIX_SLEW_SPEED    = 18'sd2250;
   localparam logic signed [17:0] AXIS_ONE          = 18'sd16384;
   localparam logic signed [15:0] WRIST_FACTOR      = 16'sd19661;
   localparam logic [4:0] SH_ANGLE = 5'd12;
   localparam logic [4:0] SH_AXIS  = 5'd14;
   localparam logic [4:0] SH_JAW   = 5'd15;
   localparam logic [4:0] SH_WRIST = 5'd30;

   typedef enum logic [1:0] {
      CMD_JOY     = 2'd0,
      CMD_CURRENT = 2'd1,
      CMD_ANGLE   = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_MANUAL       = 2'd0,
      MODE_PARK         = 2'd1,
      MODE_FIX_SLEW     = 2'd2,
      MODE_OVER_CURRENT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_GAIN  = 2'd0,
      REG_TOL   = 2'd1,
      REG_DIR   = 2'd2,
      REG_LIMIT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic               ready;
      logic               toggle;
      logic               eval;
      logic               issue;
      logic [JOINT_W-1:0] joint;
      logic               load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic joy_valid;
      logic rsp_free;
      logic park_on;
      logic fix_on;
   } dp_sts_type;

   function automatic logic signed [15:0] park_target(input logic [JOINT_W-1:0] j);
      logic signed [15:0] t;
      case (j)
         3'd1:    t = 16'sd614;
         3'd2:    t = 16'sd7373;
         3'd4:    t = 16'sd1475;
         default: t = 16'sd0;
      endcase
      return t;
   endfunction
endpackage

@@ hdl/jav_req_if.sv @@
// Request channel: joystick and measurement words.
// Depends on nothing.
interface jav_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [15:0] slew_axis;
   logic signed [15:0] shoulder_axis;
   logic signed [15:0] elbow_axis;
   logic signed [15:0] wrist_axis;
   logic signed [15:0] close_trigger;
   logic signed [15:0] open_trigger;
   logic [4:0]         button_bits;
   logic [2:0]         joint_index;
   logic signed [15:0] measurement;
   modport source (output valid, command, slew_axis, shoulder_axis, elbow_axis, wrist_axis,
                   close_trigger, open_trigger, button_bits, joint_index, measurement,
                   input ready);
   modport sink (input valid, command, slew_axis, shoulder_axis, elbow_axis, wrist_axis,
                 close_trigger, open_trigger, button_bits, joint_index, measurement,
                 output ready);
endinterface

@@ hdl/jav_rsp_if.sv @@
// Response channel: joint velocities, mode and lock flags.
// Depends on nothing.
interface jav_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] slew_velocity;
   logic signed [31:0] shoulder_velocity;
   logic signed [31:0] elbow_velocity;
   logic signed [31:0] wrist_velocity;
   logic signed [31:0] jaw_velocity;
   logic [1:0]         mode;
   logic [2:0]         lock_flags;
   modport source (output valid, slew_velocity, shoulder_velocity, elbow_velocity,
                   wrist_velocity, jaw_velocity, mode, lock_flags, input ready);
   modport sink (input valid, slew_velocity, shoulder_velocity, elbow_velocity,
                 wrist_velocity, jaw_velocity, mode, lock_flags, output ready);
endinterface

@@ hdl/jav_ctrl.sv @@
// Sequencer: toggle, evaluate, five joint issues, pipeline drain, response load.
// Depends on jav_pkg.
module jav_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  jav_pkg::dp_sts_type sts,
   output jav_pkg::dp_cmd_type cmd
);
   import jav_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TOGGLE, ST_EVAL, ST_ISSUE, ST_DRAIN, ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [JOINT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE:   if (sts.joy_valid) state_ff <= ST_TOGGLE;
            ST_TOGGLE: state_ff <= ST_EVAL;
            ST_EVAL: begin
               state_ff <= ST_ISSUE;
               cnt_ff   <= '0;
            end
            ST_ISSUE: begin
               if (cnt_ff == JOINT_W'(JOINTS - 1)) begin
                  state_ff <= ST_DRAIN;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (cnt_ff == JOINT_W'(DRAIN_CYCLES - 1)) state_ff <= ST_FINISH;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            ST_FINISH: if (sts.rsp_free) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.ready    = (state_ff == ST_IDLE);
      cmd.toggle   = (state_ff == ST_TOGGLE);
      cmd.eval     = (state_ff == ST_EVAL);
      cmd.issue    = (state_ff == ST_ISSUE);
      cmd.joint    = cnt_ff;
      cmd.load_rsp = (state_ff == ST_FINISH) && sts.rsp_free;
   end
endmodule

@@ hdl/jav_datapath.sv @@
// Datapath: settings, arm state, operand select, two-stage multiplier, truncating shift,
// velocity store and response register. Depends on jav_pkg, jav_req_if, jav_rsp_if.
module jav_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  jav_pkg::reg_index_type csr_index,
   input  logic [15:0]            csr_write_data,
   jav_req_if.sink                req,
   jav_rsp_if.source              rsp,
   input  jav_pkg::dp_cmd_type    cmd,
   output jav_pkg::dp_sts_type    sts
);
   import jav_pkg::*;

   logic [15:0]        gain_ff;
   logic [14:0]        tol_ff;
   logic [4:0]         dir_ff;
   logic signed [15:0] limit_ff;

   logic [4:0]         prev_btn_ff;
   logic [2:0]         lock_ff;
   logic               fix_ff;
   logic               park_ff;
   logic signed [15:0] angle_ff [JOINTS];
   logic signed [15:0] current_ff;

   logic signed [15:0] slew_ff, shoulder_ff, elbow_ff, wrist_ff, close_ff, open_ff;
   logic [4:0]         btn_ff;

   mode_type           mode_ff;
   logic [JOINTS-1:0]  band_ff;
   logic               fixz_ff;

   logic signed [34:0] p1_ff;
   logic signed [15:0] k1_ff;
   logic [4:0]         sh1_ff, sh2_ff;
   logic [JOINT_W-1:0] j1_ff, j2_ff;
   logic               vld1_ff, vld2_ff;
   logic signed [50:0] p2_ff;
   logic signed [31:0] v_ff [JOINTS];

   logic               rsp_valid_ff;
   logic signed [31:0] rv_ff [JOINTS];
   logic [1:0]         rmode_ff;
   logic [2:0]         rlock_ff;

   logic               accept;
   logic [4:0]         rise;
   logic               fix_in, park_in;
   logic signed [16:0] err [JOINTS];
   logic signed [16:0] tol_s;
   logic signed [16:0] ang0;
   logic [JOINTS-1:0]  band;
   logic               fixz;
   mode_type           mode_in;
   logic signed [17:0] op_a, a_n;
   logic signed [16:0] op_g;
   logic signed [15:0] op_k;
   logic [4:0]         op_sh;
   logic               op_neg, op_zero;
   logic [JOINT_W-1:0] j;
   logic signed [50:0] bias, quot;

   assign accept    = req.valid && req.ready;
   assign req.ready = cmd.ready;

   assign sts.joy_valid = req.valid && (req.command == CMD_JOY);
   assign sts.rsp_free  = !rsp_valid_ff || rsp.ready;
   assign sts.park_on   = park_ff;
   assign sts.fix_on    = fix_ff;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         tol_ff   <= '0;
         dir_ff   <= '0;
         limit_ff <= CURRENT_LIMIT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_GAIN:  gain_ff  <= csr_write_data;
            REG_TOL:   tol_ff   <= csr_write_data[14:0];
            REG_DIR:   dir_ff   <= csr_write_data[4:0];
            REG_LIMIT: limit_ff <= csr_write_data;
            default:   gain_ff  <= gain_ff;
         endcase
      end
   end

   // button edges
   always_comb begin
      rise    = btn_ff & ~prev_btn_ff;
      fix_in  = fix_ff;
      park_in = park_ff;
      if (rise[3]) begin
         fix_in = !fix_ff;
         if (fix_in) park_in = 1'b0;
      end
      if (rise[4]) begin
         park_in = !park_in;
         if (park_in) fix_in = 1'b0;
      end
   end

   always_comb begin
      tol_s = {2'b00, tol_ff};
      ang0  = {angle_ff[0][15], angle_ff[0]};
      for (int i = 0; i < JOINTS; i++) begin
         err[i]  = 17'(angle_ff[i]) - 17'(park_target(JOINT_W'(i)));
         band[i] = (err[i] <= tol_s) && (err[i] >= -tol_s);
      end
      fixz = (ang0 > -tol_s) && (ang0 < tol_s);
      if (current_ff >= limit_ff)  mode_in = MODE_OVER_CURRENT;
      else if (park_ff)            mode_in = MODE_PARK;
      else if (fix_ff)             mode_in = MODE_FIX_SLEW;
      else                         mode_in = MODE_MANUAL;
   end

   // arm state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_btn_ff <= '0;
         lock_ff     <= '0;
         fix_ff      <= 1'b0;
         park_ff     <= 1'b0;
         current_ff  <= '0;
         for (int i = 0; i < JOINTS; i++) angle_ff[i] <= '0;
      end else begin
         if (accept) begin
            case (req.command)
               CMD_CURRENT: current_ff <= req.measurement;
               CMD_ANGLE:
                  if (req.joint_index < JOINT_W'(JOINTS))
                     angle_ff[req.joint_index] <= req.measurement;
               default: ;
            endcase
         end
         if (cmd.toggle) begin
            lock_ff     <= lock_ff ^ rise[2:0];
            fix_ff      <= fix_in;
            park_ff     <= park_in;
            prev_btn_ff <= btn_ff;
         end
         if (cmd.eval) begin
            if (mode_in == MODE_PARK && (&band)) park_ff <= 1'b0;
            if (mode_in == MODE_FIX_SLEW && fixz) fix_ff <= 1'b0;
         end
      end
   end

   // joystick word and evaluation results
   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_JOY) begin
         slew_ff     <= req.slew_axis;
         shoulder_ff <= req.shoulder_axis;
         elbow_ff    <= req.elbow_axis;
         wrist_ff    <= req.wrist_axis;
         close_ff    <= req.close_trigger;
         open_ff     <= req.open_trigger;
         btn_ff      <= req.button_bits;
      end
      if (cmd.eval) begin
         mode_ff <= mode_in;
         band_ff <= band;
         fixz_ff <= fixz;
      end
   end

   // operand select
   always_comb begin
      j       = cmd.joint;
      op_a    = '0;
      op_g    = {1'b0, gain_ff};
      op_k    = 16'sd1;
      op_sh   = '0;
      op_neg  = 1'b0;
      op_zero = 1'b1;
      unique case (mode_ff)
         MODE_PARK: begin
            op_a    = {err[j][16], err[j]};
            op_g    = (j == JOINT_W'(3)) ? {3'b000, gain_ff[15:2]} : {1'b0, gain_ff};
            op_sh   = SH_ANGLE;
            op_neg  = (j != JOINT_W'(2));
            op_zero = band_ff[j];
         end
         MODE_FIX_SLEW: begin
            if (j == JOINT_W'(0) && !fixz_ff) begin
               op_a    = (angle_ff[0] > 16'sd0) ? -FIX_SLEW_SPEED : FIX_SLEW_SPEED;
               op_g    = 17'sd1;
               op_zero = 1'b0;
            end
         end
         MODE_MANUAL: begin
            case (j)
               3'd0: begin
                  op_a    = {{2{slew_ff[15]}}, slew_ff};
                  op_sh   = SH_AXIS;
                  op_neg  = dir_ff[0];
                  op_zero = !(slew_ff > SLEW_DEADZONE || slew_ff < -SLEW_DEADZONE) ||
                            lock_ff[0];
               end
               3'd1: begin
                  op_a    = {{2{shoulder_ff[15]}}, shoulder_ff};
                  op_sh   = SH_AXIS;
                  op_neg  = dir_ff[1];
                  op_zero = 1'b0;
               end
               3'd2: begin
                  op_a    = {{2{elbow_ff[15]}}, elbow_ff};
                  op_sh   = SH_AXIS;
                  op_neg  = dir_ff[2];
                  op_zero = 1'b0;
               end
               3'd3: begin
                  op_a    = {{2{wrist_ff[15]}}, wrist_ff};
                  op_k    = WRIST_FACTOR;
                  op_sh   = SH_WRIST;
                  op_neg  = dir_ff[3];
                  op_zero = lock_ff[1];
               end
               3'd4: begin
                  op_sh = SH_JAW;
                  if (close_ff < open_ff) begin
                     op_a    = {{2{close_ff[15]}}, close_ff} - AXIS_ONE;
                     op_neg  = dir_ff[4];
                     op_zero = (close_ff == 16'sd0);
                  end else if (close_ff > open_ff) begin
                     op_a    = {{2{open_ff[15]}}, open_ff} - AXIS_ONE;
                     op_neg  = !dir_ff[4];
                     op_zero = (open_ff == 16'sd0) || lock_ff[2];
                  end
               end
               default: op_zero = 1'b1;
            endcase
         end
         default: op_zero = 1'b1;
      endcase
      a_n = op_zero ? 18'sd0 : (op_neg ? -op_a : op_a);
   end

   // multiply pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= cmd.issue;
         vld2_ff <= vld1_ff;
      end
   end

   always_comb begin
      bias = p2_ff[50] ? ((51'sd1 <<< sh2_ff) - 51'sd1) : 51'sd0;
      quot = (p2_ff + bias) >>> sh2_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         p1_ff  <= a_n * op_g;
         k1_ff  <= op_k;
         sh1_ff <= op_sh;
         j1_ff  <= j;
      end
      if (vld1_ff) begin
         p2_ff  <= p1_ff * k1_ff;
         sh2_ff <= sh1_ff;
         j2_ff  <= j1_ff;
      end
      if (vld2_ff) v_ff[j2_ff] <= quot[31:0];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         for (int i = 0; i < JOINTS; i++) rv_ff[i] <= v_ff[i];
         rmode_ff <= mode_ff;
         rlock_ff <= lock_ff;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.slew_velocity     = rv_ff[0];
   assign rsp.shoulder_velocity = rv_ff[1];
   assign rsp.elbow_velocity    = rv_ff[2];
   assign rsp.wrist_velocity    = rv_ff[3];
   assign rsp.jaw_velocity      = rv_ff[4];
   assign rsp.mode              = rmode_ff;
   assign rsp.lock_flags        = rlock_ff;
endmodule

@@ hdl/joystick_arm_velocity_controller_unit.sv @@
// Arm velocity controller top level. Measurement words are taken back to back while
// the sequencer is idle. After a joystick word no further word is taken until its
// response word is loaded: the sequencer runs toggle, evaluate, five joint passes
// through the shared two-stage multiplier, drain and the response load; a stalled
// response word holds the sequencer.
// Reset (synchronous, active high) clears settings, locks, modes, angles; limit 1536.
`include "assert_macros.svh"
module joystick_arm_velocity_controller_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  jav_pkg::reg_index_type csr_index,
   input  logic [15:0]            csr_write_data,
   jav_req_if.sink                req_bus,
   jav_rsp_if.source              rsp_bus
);
   import jav_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   jav_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (dp_sts),
      .cmd   (dp_cmd)
   );

   jav_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .cmd              (dp_cmd),
      .sts              (dp_sts)
   );

   `JAV_ASSERT_IMPLIES(a_modes_exclusive, clock, reset, 1'b1, !(dp_sts.park_on && dp_sts.fix_on))
   `JAV_ASSERT_IMPLIES(a_over_current_zero, clock, reset, rsp_bus.valid && rsp_bus.mode == MODE_OVER_CURRENT, rsp_bus.slew_velocity == 32'sd0 && rsp_bus.shoulder_velocity == 32'sd0 && rsp_bus.elbow_velocity == 32'sd0 && rsp_bus.wrist_velocity == 32'sd0 && rsp_bus.jaw_velocity == 32'sd0)
   `JAV_ASSERT_NEXT(a_joy_busy, clock, reset, req_bus.valid && req_bus.ready && req_bus.command == CMD_JOY, !req_bus.ready)
endmodule

@@ sim/joystick_arm_velocity_controller_unit_tb.sv @@
// Self-checking testbench for the arm velocity controller: random and directed words,
// predicted responses checked field by field. Depends on jav_pkg, jav_req_if, jav_rsp_if.
`timescale 1ns / 100ps
module joystick_arm_velocity_controller_unit_tb;
   import jav_pkg::*;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] slew_axis;
      logic signed [15:0] shoulder_axis;
      logic signed [15:0] elbow_axis;
      logic signed [15:0] wrist_axis;
      logic signed [15:0] close_trigger;
      logic signed [15:0] open_trigger;
      logic [4:0]         button_bits;
      logic [2:0]         joint_index;
      logic signed [15:0] measurement;
   } arm_word_type;

   typedef struct packed {
      logic signed [31:0] slew_v;
      logic signed [31:0] shoulder_v;
      logic signed [31:0] elbow_v;
      logic signed [31:0] wrist_v;
      logic signed [31:0] jaw_v;
      logic [1:0]         mode;
      logic [2:0]         locks;
   } velocity_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   reg_index_type csr_index = REG_GAIN;
   logic [15:0] csr_write_data = '0;

   jav_req_if req_bus ();
   jav_rsp_if rsp_bus ();

   joystick_arm_velocity_controller_unit dut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] gain_reg;
   logic [14:0] tol_reg;
   logic [4:0]  dir_reg;
   logic signed [15:0] limit_reg;
   logic [4:0]  prev_buttons;
   logic [2:0]  lock_state;
   logic        fix_on, park_on;
   logic signed [15:0] angle_mem [JOINTS];
   logic signed [15:0] current_val;

   arm_word_type      pending_words[$];
   velocity_word_type expected_vel[$];
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  hold_send = 0;
   bit  req_taken = 0;
   int  mismatches = 0;
   longint cycles = 0;

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint dsign(int j);
      return dir_reg[j] ? -1 : 1;
   endfunction

   function automatic void add_word(input arm_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   task automatic predict_velocity(input arm_word_type w);
      longint vel[JOINTS];
      longint g, tol, e, gj, p, s, c, o, a;
      logic [4:0] rise;
      int in_band;
      mode_type m;
      velocity_word_type r;
      g = gain_reg; tol = tol_reg;
      for (int j = 0; j < JOINTS; j++) vel[j] = 0;
      if (w.command == CMD_CURRENT) begin
         current_val = w.measurement;
         return;
      end
      if (w.command == CMD_ANGLE) begin
         if (w.joint_index < JOINTS) angle_mem[w.joint_index] = w.measurement;
         return;
      end
      if (w.command != CMD_JOY) return;
      rise = w.button_bits & ~prev_buttons;
      lock_state ^= rise[2:0];
      if (rise[3]) begin
         fix_on = !fix_on;
         if (fix_on) park_on = 0;
      end
      if (rise[4]) begin
         park_on = !park_on;
         if (park_on) fix_on = 0;
      end
      if (current_val >= limit_reg) begin
         m = MODE_OVER_CURRENT;
      end else if (park_on) begin
         m = MODE_PARK;
         in_band = 0;
         for (int j = 0; j < JOINTS; j++) begin
            e = longint'(angle_mem[j]) - longint'(park_target(j[JOINT_W-1:0]));
            gj = (j == 3) ? g / 4 : g;
            if (e > tol || e < -tol) begin
               p = gj * e / 4096;
               vel[j] = (j == 2) ? p : -p;
            end else in_band++;
         end
         if (in_band == JOINTS) park_on = 0;
      end else if (fix_on) begin
         m = MODE_FIX_SLEW;
         a = angle_mem[0];
         if (a > -tol && a < tol) fix_on = 0;
         else vel[0] = (a > 0) ? -2250 : 2250;
      end else begin
         m = MODE_MANUAL;
         s = w.slew_axis; c = w.close_trigger; o = w.open_trigger;
         if ((s > 3276 || s < -3276) && !lock_state[0]) vel[0] = g * s * dsign(0) / 16384;
         vel[1] = g * longint'(w.shoulder_axis) * dsign(1) / 16384;
         vel[2] = g * longint'(w.elbow_axis) * dsign(2) / 16384;
         if (!lock_state[1])
            vel[3] = g * longint'(w.wrist_axis) * dsign(3) * 19661 / 1073741824;
         if (c < o) begin
            if (c != 0) vel[4] = g * (c - 16384) * dsign(4) / 32768;
         end else if (c > o) begin
            if (o != 0 && !lock_state[2]) vel[4] = -(g * (o - 16384) * dsign(4) / 32768);
         end
      end
      prev_buttons = w.button_bits;
      r.slew_v = sat32(vel[0]); r.shoulder_v = sat32(vel[1]); r.elbow_v = sat32(vel[2]);
      r.wrist_v = sat32(vel[3]); r.jaw_v = sat32(vel[4]);
      r.mode = m; r.locks = lock_state;
      expected_vel.insert(expected_vel.size(), r);
   endtask

   // driver
   arm_word_type cur_word;
   initial begin
      req_bus.valid = 1'b0;
      {req_bus.command, req_bus.slew_axis, req_bus.shoulder_axis, req_bus.elbow_axis,
       req_bus.wrist_axis, req_bus.close_trigger, req_bus.open_trigger,
       req_bus.button_bits, req_bus.joint_index, req_bus.measurement} = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_taken) begin
            req_taken = 1'b0;
            if (!hold_send && pending_words.size() > 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               cur_word = pending_words.pop_front();
               {req_bus.command, req_bus.slew_axis, req_bus.shoulder_axis,
                req_bus.elbow_axis, req_bus.wrist_axis, req_bus.close_trigger,
                req_bus.open_trigger, req_bus.button_bits, req_bus.joint_index,
                req_bus.measurement} = cur_word;
               req_bus.valid <= 1'b1;
            end else req_bus.valid <= 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // acceptance and monitor
   always @(posedge clock) begin
      arm_word_type w;
      velocity_word_type got, want;
      cycles++;
      if (!reset && req_bus.valid && req_bus.ready) begin
         w = {req_bus.command, req_bus.slew_axis, req_bus.shoulder_axis, req_bus.elbow_axis,
              req_bus.wrist_axis, req_bus.close_trigger, req_bus.open_trigger,
              req_bus.button_bits, req_bus.joint_index, req_bus.measurement};
         req_taken = 1'b1;
         predict_velocity(w);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.slew_velocity, rsp_bus.shoulder_velocity, rsp_bus.elbow_velocity,
                rsp_bus.wrist_velocity, rsp_bus.jaw_velocity, rsp_bus.mode,
                rsp_bus.lock_flags};
         if (expected_vel.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %p", got);
         end else begin
            want = expected_vel.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_GAIN:  gain_reg = val;
         REG_TOL:   tol_reg = val[14:0];
         REG_DIR:   dir_reg = val[4:0];
         REG_LIMIT: limit_reg = val;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_bus.valid || expected_vel.size() > 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5, 0))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return $signed(16'($urandom_range(32768, 0))) - 16'sd16384;
      endcase
   endfunction

   function automatic arm_word_type joy_word(input logic [4:0] b);
      arm_word_type w;
      w = '0;
      w.command = CMD_JOY;
      w.slew_axis = rand_axis(); w.shoulder_axis = rand_axis(); w.elbow_axis = rand_axis();
      w.wrist_axis = rand_axis(); w.close_trigger = rand_axis();
      w.open_trigger = rand_axis(); w.button_bits = b;
      return w;
   endfunction

   function automatic arm_word_type meas_word(input command_type c, input logic [2:0] j,
                                              input logic signed [15:0] m);
      arm_word_type w;
      w = joy_word(5'($urandom));
      w.command = c; w.joint_index = j; w.measurement = m;
      return w;
   endfunction

   function automatic arm_word_type random_word();
      int k;
      logic signed [15:0] m;
      k = $urandom_range(99, 0);
      m = 16'($urandom);
      if ($urandom_range(3, 0) == 0) m = $signed(16'($urandom_range(16383, 0))) - 16'sd8192;
      if (k < 60) return joy_word(($urandom_range(2, 0) == 0) ? 5'($urandom) : 5'd0);
      if (k < 70) return meas_word(CMD_CURRENT, 3'd0,
                                   ($urandom_range(3, 0) == 0) ? m : -16'sd256);
      if (k < 95) return meas_word(CMD_ANGLE, 3'($urandom_range(7, 0)), m);
      return meas_word(CMD_NONE, 3'($urandom), m);
   endfunction

   task automatic directed_set();
      add_word(meas_word(CMD_ANGLE, 3'd0, 16'sd100));
      add_word(joy_word(5'd0));
      add_word(joy_word(5'b00111));
      add_word(joy_word(5'd0));
      add_word(joy_word(5'b01000));
      add_word(joy_word(5'b11000));
      for (int j = 0; j < 8; j++)
         add_word(meas_word(CMD_ANGLE, 3'(j), 16'sh7fff));
      add_word(joy_word(5'd0));
      add_word(joy_word(5'b10000));
      for (int j = 0; j < JOINTS; j++)
         add_word(meas_word(CMD_ANGLE, 3'(j), park_target(j[JOINT_W-1:0])));
      add_word(joy_word(5'd0));
      add_word(meas_word(CMD_ANGLE, 3'd0, -16'sh8000));
      add_word(meas_word(CMD_CURRENT, 3'd0, 16'sd1536));
      add_word(joy_word(5'b11111));
      add_word(meas_word(CMD_NONE, 3'd7, 16'sh7fff));
      add_word(meas_word(CMD_CURRENT, 3'd0, -16'sh8000));
      add_word(joy_word(5'd0));
   endtask

   initial begin
      gain_reg = 0; tol_reg = 0; dir_reg = 0; limit_reg = CURRENT_LIMIT_RST;
      prev_buttons = 0; lock_state = 0; fix_on = 0; park_on = 0; current_val = 0;
      for (int j = 0; j < JOINTS; j++) angle_mem[j] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_reg(REG_GAIN, 16'hffff);
      write_reg(REG_TOL, 16'd0);
      write_reg(REG_DIR, 16'd0);
      write_reg(REG_LIMIT, 16'h7fff);
      send_idle_pct = 19; recv_idle_pct = 68;
      directed_set();
      wait_drained();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 19; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_reg(REG_GAIN, (phase == 5) ? 16'd0 : 16'($urandom));
         write_reg(REG_TOL, (phase == 1) ? 16'h7fff : 16'($urandom_range(600, 0)));
         write_reg(REG_DIR, (phase == 2) ? 16'd31 : 16'($urandom_range(31, 0)));
         write_reg(REG_LIMIT, (phase == 4) ? 16'h8000 : 16'($urandom_range(3000, 0)));
         for (int i = 0; i < 170; i++) begin
            add_word(random_word());
            if (phase == 0 && i == 80) begin
               while (pending_words.size() > 0) @(negedge clock);
               hold_send = 1;
               while (req_bus.valid || expected_vel.size() > 0) @(negedge clock);
               hold_send = 0;
            end
         end
         wait_drained();
      end
      if (mismatches == 0 && expected_vel.size() == 0)
         $display("** joystick_arm_velocity_controller_unit: PASSED **");
      else
         $display("** joystick_arm_velocity_controller_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("** joystick_arm_velocity_controller_unit: FAILED **");
         $finish;
      end
   end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/jav_pkg.sv
hdl/jav_req_if.sv
hdl/jav_rsp_if.sv
hdl/jav_ctrl.sv
hdl/jav_datapath.sv
hdl/joystick_arm_velocity_controller_unit.sv
sim/joystick_arm_velocity_controller_unit_tb.sv
